@@ hdl/bes_pkg.sv @@
// ============================================================================
// bes_pkg
// Shared types, character codes and helpers for the expression scanner.
// ============================================================================
package bes_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam int ENTRY_W   = 10;
    localparam int DEPTH_W   = 16;
    localparam int INTERP_W  = 9;
    localparam int LEN_OUT_W = 16;

    localparam logic [DEPTH_W-1:0]  DEPTH_MAX  = '1;
    localparam logic [INTERP_W-1:0] INTERP_MAX = '1;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_BQUOTE = 8'h60;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef enum logic [1:0] {
        Q_NONE   = 2'd0,
        Q_SINGLE = 2'd1,
        Q_DOUBLE = 2'd2,
        Q_BACK   = 2'd3
    } t_quote;

    typedef enum logic [1:0] {
        ST_NONE     = 2'd0,
        ST_FOUND    = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_SPACE = 2'd1,
        PH_SCAN  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        OP_HOLD  = 2'd0,
        OP_PUSH  = 2'd1,
        OP_POP   = 2'd2,
        OP_WRITE = 2'd3
    } t_stack_op;

    typedef struct packed {
        t_stack_op          op;
        logic [ENTRY_W-1:0] entry;
    } t_stack_ctl;

    function automatic t_quote quote_code(input logic [7:0] c);
        t_quote q;
        case (c)
            CH_SQUOTE: q = Q_SINGLE;
            CH_DQUOTE: q = Q_DOUBLE;
            CH_BQUOTE: q = Q_BACK;
            default:   q = Q_NONE;
        endcase
        return q;
    endfunction

endpackage

@@ hdl/bes_stack_cell.sv @@
// ============================================================================
// bes_stack_cell
// One entry of the shifting context stack; takes its upper or lower neighbor.
// ============================================================================
module bes_stack_cell
    import bes_pkg::*;
(
    input  logic               i_clk,
    input  t_stack_op          i_op,
    input  logic [ENTRY_W-1:0] i_up,
    input  logic [ENTRY_W-1:0] i_down,
    output logic [ENTRY_W-1:0] o_entry
);

    logic [ENTRY_W-1:0] r_entry;
    logic [ENTRY_W-1:0] n_entry;

    always_comb begin
        case (i_op)
            OP_PUSH:  n_entry = i_up;
            OP_WRITE: n_entry = i_up;
            OP_POP:   n_entry = i_down;
            default:  n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

@@ hdl/bes_stack.sv @@
// ============================================================================
// bes_stack
// Context stack built as a row of cells; the top entry always sits in cell 0.
// ============================================================================
module bes_stack
    import bes_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic               i_clk,
    input  t_stack_ctl         i_ctl,
    output logic [ENTRY_W-1:0] o_top
);

    logic [ENTRY_W-1:0] w_entry [STACK_DEPTH];
    t_stack_op          w_lower_op;

    // Only the top cell takes a rewrite of its entry.
    assign w_lower_op = (i_ctl.op == OP_WRITE) ? OP_HOLD : i_ctl.op;

    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        logic [ENTRY_W-1:0] w_up;
        logic [ENTRY_W-1:0] w_down;
        t_stack_op          w_op;

        if (g == 0) begin : g_head
            assign w_up = i_ctl.entry;
            assign w_op = i_ctl.op;
        end else begin : g_body
            assign w_up = w_entry[g-1];
            assign w_op = w_lower_op;
        end

        if (g == STACK_DEPTH - 1) begin : g_tail
            assign w_down = w_entry[g];
        end else begin : g_mid
            assign w_down = w_entry[g+1];
        end

        bes_stack_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (w_op),
            .i_up    (w_up),
            .i_down  (w_down),
            .o_entry (w_entry[g])
        );
    end

    assign o_top = w_entry[0];

endmodule

@@ hdl/balanced_expression_scanner_core.sv @@
// ============================================================================
// balanced_expression_scanner_core
// Scans a character stream for the extent of a bracket-balanced expression.
// ============================================================================
// A result is registered in the output stage, or in the skid register if that is held.
// Throughput: one character request per cycle; every step reads only cell 0 of the stack.
// The input stalls only while a second result waits in the skid register.
// Synchronous active-low reset clears the scan state, ts_mode and the output stage.
// The stack cells are not reset; an entry is read only after it has been pushed.
module balanced_expression_scanner_core
    import bes_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,       // ts_mode
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // char_code
    input  logic        i_s_axis_tuser,   // start_scan
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // ts_tag, token_length, zero fill
    output logic [1:0]  o_m_axis_tuser    // status
);

    localparam int LVL_W = $clog2(STACK_DEPTH + 1);
    localparam int LW    = (COUNT_WIDTH > LEN_OUT_W) ? COUNT_WIDTH : LEN_OUT_W;

    t_phase                 r_phase, n_phase;
    logic [DEPTH_W-1:0]     r_depth, n_depth;
    logic                   r_has, n_has;
    logic [LVL_W-1:0]       r_level, n_level;
    logic                   r_esc, n_esc;
    logic                   r_dol, n_dol;
    logic [COUNT_WIDTH-1:0] r_len, n_len;
    logic                   r_ts;

    logic                   r_out_valid, r_skid_valid;
    t_status                r_out_status, r_skid_status;
    logic                   r_out_ts, r_skid_ts;
    logic [LEN_OUT_W-1:0]   r_out_len, r_skid_len;

    logic                   w_acc;
    logic [7:0]             w_c;
    t_phase                 w_ph;
    logic [DEPTH_W-1:0]     w_depth;
    logic                   w_has;
    logic [LVL_W-1:0]       w_level;
    logic                   w_esc, w_dol;
    logic [COUNT_WIDTH-1:0] w_len, w_len_inc;
    logic [ENTRY_W-1:0]     w_top;
    t_quote                 w_q, w_tq;
    logic [INTERP_W-1:0]    w_n;
    logic                   w_full, w_space, w_reject;
    logic                   w_fin, w_enter_scan;
    t_status                w_status;
    t_stack_ctl             w_ctl;
    logic [LW-1:0]          w_len_ext;
    logic [LEN_OUT_W-1:0]   w_len_out;
    logic                   w_pop_out;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = !r_skid_valid;
    assign w_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign w_c             = i_s_axis_tdata;

    // A start request sees a freshly cleared scan.
    assign w_ph      = i_s_axis_tuser ? PH_SPACE : r_phase;
    assign w_depth   = i_s_axis_tuser ? '0 : r_depth;
    assign w_has     = i_s_axis_tuser ? 1'b0 : r_has;
    assign w_level   = i_s_axis_tuser ? '0 : r_level;
    assign w_esc     = i_s_axis_tuser ? 1'b0 : r_esc;
    assign w_dol     = i_s_axis_tuser ? 1'b0 : r_dol;
    assign w_len     = i_s_axis_tuser ? '0 : r_len;
    assign w_len_inc = (w_len == '1) ? w_len : w_len + 1'b1;

    assign w_q    = quote_code(w_c);
    assign w_tq   = t_quote'(w_top[1:0]);
    assign w_n    = w_top[INTERP_W-1:0];
    assign w_full = (w_level == LVL_W'(STACK_DEPTH));

    assign w_space  = (w_c == CH_SPACE) || (w_c == CH_TAB) || (w_c == CH_LF)
                   || (w_c == CH_CR);
    assign w_reject = (w_c == CH_NUL) || (w_c == CH_HASH) || (w_c == CH_COLON)
                   || (w_c == CH_AT) || (w_c == CH_SLASH);

    always_comb begin
        w_fin        = 1'b0;
        w_status     = ST_NONE;
        w_enter_scan = 1'b0;
        w_ctl.op     = OP_HOLD;
        w_ctl.entry  = '0;
        n_depth      = w_depth;
        n_has        = w_has;
        n_level      = w_level;
        n_esc        = w_esc;
        n_dol        = w_dol;
        n_len        = w_len;
        if (w_ph == PH_SPACE && w_space) begin
            w_fin = 1'b0;
        end else if (w_ph == PH_SPACE && w_reject) begin
            w_fin    = 1'b1;
            w_status = ST_NONE;
        end else if (w_ph != PH_IDLE) begin
            w_enter_scan = 1'b1;
            n_len        = w_len_inc;
            if (w_c == CH_NUL) begin
                w_fin    = 1'b1;
                w_status = w_has ? ST_FOUND : ST_NONE;
            end else if (w_level == '0) begin
                n_has = 1'b1;
                if (w_depth == '0 && w_c == CH_RBRACE) begin
                    w_fin    = 1'b1;
                    w_status = w_has ? ST_FOUND : ST_NONE;
                end else if (w_q != Q_NONE) begin
                    if (w_full) begin
                        w_fin    = 1'b1;
                        w_status = ST_OVERFLOW;
                    end else begin
                        w_ctl.op    = OP_PUSH;
                        w_ctl.entry = ENTRY_W'(w_q);
                        n_level     = w_level + 1'b1;
                    end
                end else if (w_c == CH_LPAREN || w_c == CH_LBRACK || w_c == CH_LBRACE) begin
                    if (w_depth == DEPTH_MAX) begin
                        w_fin    = 1'b1;
                        w_status = ST_OVERFLOW;
                    end else begin
                        n_depth = w_depth + 1'b1;
                    end
                end else if (w_c == CH_RPAREN || w_c == CH_RBRACK || w_c == CH_RBRACE) begin
                    if (w_depth == '0) begin
                        w_fin    = 1'b1;
                        w_status = w_has ? ST_FOUND : ST_NONE;
                    end else begin
                        n_depth = w_depth - 1'b1;
                    end
                end
            end else if (w_top[ENTRY_W-1]) begin
                if (w_q != Q_NONE) begin
                    if (w_full) begin
                        w_fin    = 1'b1;
                        w_status = ST_OVERFLOW;
                    end else begin
                        w_ctl.op    = OP_PUSH;
                        w_ctl.entry = ENTRY_W'(w_q);
                        n_level     = w_level + 1'b1;
                    end
                end else if (w_c == CH_LBRACE) begin
                    if (w_n == INTERP_MAX) begin
                        w_fin    = 1'b1;
                        w_status = ST_OVERFLOW;
                    end else begin
                        w_ctl.op    = OP_WRITE;
                        w_ctl.entry = {1'b1, w_n + 1'b1};
                    end
                end else if (w_c == CH_RBRACE) begin
                    if (w_n <= INTERP_W'(1)) begin
                        w_ctl.op = OP_POP;
                        n_level  = w_level - 1'b1;
                    end else begin
                        w_ctl.op    = OP_WRITE;
                        w_ctl.entry = {1'b1, w_n - 1'b1};
                    end
                end
            end else if (w_esc) begin
                n_esc = 1'b0;
            end else if (w_dol && w_tq == Q_BACK && w_c == CH_LBRACE) begin
                n_dol = 1'b0;
                if (w_full) begin
                    w_fin    = 1'b1;
                    w_status = ST_OVERFLOW;
                end else begin
                    w_ctl.op    = OP_PUSH;
                    w_ctl.entry = {1'b1, INTERP_W'(1)};
                    n_level     = w_level + 1'b1;
                end
            end else begin
                n_dol = 1'b0;
                if (w_q != Q_NONE && w_q == w_tq) begin
                    w_ctl.op = OP_POP;
                    n_level  = w_level - 1'b1;
                end else if (w_c == CH_BSLASH) begin
                    n_esc = 1'b1;
                end else if (w_tq == Q_BACK && w_c == CH_DOLLAR) begin
                    n_dol = 1'b1;
                end
            end
        end
        if (w_fin) begin
            w_ctl.op = OP_HOLD;
            n_depth  = '0;
            n_has    = 1'b0;
            n_level  = '0;
            n_esc    = 1'b0;
            n_dol    = 1'b0;
            n_len    = '0;
        end
        if (!w_acc) begin
            w_ctl.op = OP_HOLD;
        end
    end

    always_comb begin
        if (!w_acc) begin
            n_phase = r_phase;
        end else if (w_fin) begin
            n_phase = PH_IDLE;
        end else if (w_enter_scan) begin
            n_phase = PH_SCAN;
        end else begin
            n_phase = w_ph;
        end
    end

    assign w_len_ext = LW'(w_len);
    assign w_len_out = (w_len_ext > LW'({LEN_OUT_W{1'b1}})) ? '1 : w_len_ext[LEN_OUT_W-1:0];

    bes_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk (i_clk),
        .i_ctl (w_ctl),
        .o_top (w_top)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_depth <= '0;
            r_has   <= 1'b0;
            r_level <= '0;
            r_esc   <= 1'b0;
            r_dol   <= 1'b0;
            r_len   <= '0;
        end else if (w_acc) begin
            r_phase <= n_phase;
            r_depth <= n_depth;
            r_has   <= n_has;
            r_level <= n_level;
            r_esc   <= n_esc;
            r_dol   <= n_dol;
            r_len   <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ts <= 1'b0;
        end else if (i_cfg_valid) begin
            r_ts <= i_cfg_data;
        end
    end

    assign w_pop_out = r_out_valid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || w_pop_out) begin
            r_out_valid  <= r_skid_valid || (w_acc && w_fin);
            r_skid_valid <= 1'b0;
        end else if (w_acc && w_fin) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_pop_out) begin
            if (r_skid_valid) begin
                r_out_status <= r_skid_status;
                r_out_ts     <= r_skid_ts;
                r_out_len    <= r_skid_len;
            end else begin
                r_out_status <= w_status;
                r_out_ts     <= (w_status == ST_FOUND) ? r_ts : 1'b0;
                r_out_len    <= w_len_out;
            end
        end
        if (!r_skid_valid) begin
            r_skid_status <= w_status;
            r_skid_ts     <= (w_status == ST_FOUND) ? r_ts : 1'b0;
            r_skid_len    <= w_len_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out_len, r_out_ts};
    assign o_m_axis_tuser  = r_out_status;

endmodule

@@ sim/tb_balanced_expression_scanner_core.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_balanced_expression_scanner_core
// Self-checking bench for the expression scanner. A scoreboard class mirrors
// the scan state for every accepted character request and queues the
// expected extent reports. Each report from the block is checked against the
// oldest entry. The stimulus has directed cases, the counter and stack
// limits, and random scans with noise, with idle cycles and stalls on both
// sides.
// ============================================================================
module tb_balanced_expression_scanner_core;
    import bes_pkg::*;

    localparam int SPAN_MAX = (1 << COUNT_WIDTH_DEF) - 1;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES = 400;
    localparam int LIVE_TARGET = 900;
    localparam int FIRST_TARGET = 750;

    localparam logic [7:0] BLANKS [4] = '{CH_SPACE, CH_TAB, CH_LF, CH_CR};
    localparam logic [7:0] REJECTS [4] = '{CH_HASH, CH_COLON, CH_AT, CH_SLASH};
    localparam logic [7:0] HOT_CHARS [16] = '{
        CH_SQUOTE, CH_DQUOTE, CH_BQUOTE, CH_BQUOTE, CH_DOLLAR, CH_DOLLAR,
        CH_LBRACE, CH_LBRACE, CH_RBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN,
        CH_LBRACK, CH_RBRACK, CH_BSLASH, CH_SPACE
    };

    typedef struct {
        t_status     status;
        logic        ts;
        logic [15:0] len;
    } t_extent;

    class t_extent_scoreboard;
        t_phase      ph;
        logic [15:0] nest;
        bit          body;
        logic [9:0]  ctx [STACK_DEPTH_DEF];
        int          lvl;
        bit          esc_armed;
        bit          dollar_armed;
        int          span;
        logic        ts_flag;
        int          n_live;
        int          n_bad;
        t_extent     due_extents[$];

        function new();
            ph = PH_IDLE;
            ts_flag = 1'b0;
            n_live = 0;
            n_bad = 0;
            restart();
        endfunction

        function void restart();
            nest = '0;
            body = 1'b0;
            lvl = 0;
            esc_armed = 1'b0;
            dollar_armed = 1'b0;
            span = 0;
        endfunction

        function int pending();
            return due_extents.size();
        endfunction

        function void flag(string msg);
            n_bad++;
            if (n_bad <= 10) begin
                $display("%0t mismatch: %s", $realtime, msg);
            end
        endfunction

        function t_quote quote_of(logic [7:0] c);
            case (c)
                CH_SQUOTE: return Q_SINGLE;
                CH_DQUOTE: return Q_DOUBLE;
                CH_BQUOTE: return Q_BACK;
                default:   return Q_NONE;
            endcase
        endfunction

        function void bump_len();
            if (span < SPAN_MAX) begin
                span++;
            end
        endfunction

        function void close_scan(t_status s);
            t_extent e;
            e.status = s;
            e.ts = (s == ST_FOUND) ? ts_flag : 1'b0;
            e.len = 16'(span);
            due_extents.push_back(e);
            ph = PH_IDLE;
            restart();
        endfunction

        function bit ctx_push(logic [9:0] e);
            if (lvl >= STACK_DEPTH_DEF) begin
                return 1'b0;
            end
            ctx[lvl] = e;
            lvl++;
            return 1'b1;
        endfunction

        function void walk(logic [7:0] c);
            t_quote     q;
            t_quote     tq;
            logic [9:0] top;
            logic [8:0] n;
            q = quote_of(c);
            if (c == CH_NUL) begin
                close_scan(body ? ST_FOUND : ST_NONE);
                return;
            end
            if (lvl == 0) begin
                if (nest == 0 && c == CH_RBRACE) begin
                    close_scan(body ? ST_FOUND : ST_NONE);
                    return;
                end
                if (q != Q_NONE) begin
                    if (!ctx_push({8'd0, q})) begin
                        close_scan(ST_OVERFLOW);
                        return;
                    end
                end else if (c == CH_LPAREN || c == CH_LBRACK || c == CH_LBRACE) begin
                    if (nest == DEPTH_MAX) begin
                        close_scan(ST_OVERFLOW);
                        return;
                    end
                    nest++;
                end else if (c == CH_RPAREN || c == CH_RBRACK || c == CH_RBRACE) begin
                    if (nest == 0) begin
                        close_scan(body ? ST_FOUND : ST_NONE);
                        return;
                    end
                    nest--;
                end
                bump_len();
                body = 1'b1;
                return;
            end
            top = ctx[lvl-1];
            if (top[9]) begin
                n = top[8:0];
                if (q != Q_NONE) begin
                    if (!ctx_push({8'd0, q})) begin
                        close_scan(ST_OVERFLOW);
                        return;
                    end
                end else if (c == CH_LBRACE) begin
                    if (n == INTERP_MAX) begin
                        close_scan(ST_OVERFLOW);
                        return;
                    end
                    ctx[lvl-1] = {1'b1, n + 9'd1};
                end else if (c == CH_RBRACE) begin
                    if (n <= 1) begin
                        lvl--;
                    end else begin
                        ctx[lvl-1] = {1'b1, n - 9'd1};
                    end
                end
                bump_len();
                return;
            end
            tq = t_quote'(top[1:0]);
            if (esc_armed) begin
                esc_armed = 1'b0;
                bump_len();
                return;
            end
            if (dollar_armed) begin
                dollar_armed = 1'b0;
                if (tq == Q_BACK && c == CH_LBRACE) begin
                    if (!ctx_push({1'b1, 9'd1})) begin
                        close_scan(ST_OVERFLOW);
                        return;
                    end
                    bump_len();
                    return;
                end
            end
            if (q != Q_NONE && q == tq) begin
                lvl--;
            end else if (c == CH_BSLASH) begin
                esc_armed = 1'b1;
            end else if (tq == Q_BACK && c == CH_DOLLAR) begin
                dollar_armed = 1'b1;
            end
            bump_len();
        endfunction

        function void note_char(logic [7:0] c, logic st);
            if (st) begin
                restart();
                ph = PH_SPACE;
            end
            if (ph == PH_IDLE) begin
                return;
            end
            n_live++;
            if (ph == PH_SPACE) begin
                if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) begin
                    return;
                end
                if (c == CH_NUL || c == CH_HASH || c == CH_COLON || c == CH_AT ||
                    c == CH_SLASH) begin
                    close_scan(ST_NONE);
                    return;
                end
                ph = PH_SCAN;
            end
            walk(c);
        endfunction

        function void check_extent(logic [1:0] st, logic ts, logic [15:0] len);
            t_extent want;
            if (due_extents.size() == 0) begin
                flag($sformatf("unexpected result: status %0d ts %0b len %0d", st, ts, len));
                return;
            end
            want = due_extents.pop_front();
            if (st !== want.status || ts !== want.ts || len !== want.len) begin
                flag($sformatf("expected status %0d ts %0b len %0d, got status %0d ts %0b len %0d",
                               want.status, want.ts, want.len, st, ts, len));
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_data = 1'b0;
    logic        tx_tvalid = 1'b0;
    logic [7:0]  tx_tdata = '0;
    logic        tx_tuser = 1'b0;
    logic        rx_tready = 1'b0;
    logic        o_cfg_ready;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [23:0] o_m_axis_tdata;
    logic [1:0]  o_m_axis_tuser;

    bit quiet = 1'b0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;

    t_extent_scoreboard sb = new();

    balanced_expression_scanner_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (tx_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (tx_tdata),
        .i_s_axis_tuser  (tx_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (rx_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (rst_n) begin
            if (o_m_axis_tvalid && rx_tready) begin
                sb.check_extent(o_m_axis_tuser, o_m_axis_tdata[0], o_m_axis_tdata[16:1]);
            end
            if (tx_tvalid && o_s_axis_tready) begin
                sb.note_char(tx_tdata, tx_tuser);
            end
        end
    end

    // The result side stalls at random, or for a long hold-off when asked.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                rx_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                rx_tready <= quiet || ($urandom_range(0, 99) >= 6);
            end
        end
    end

    task automatic send_char(input logic [7:0] c, input logic st);
        while (!quiet && $urandom_range(0, 99) < 6) begin
            tx_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        tx_tvalid <= 1'b1;
        tx_tdata <= c;
        tx_tuser <= st;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic send_str(input string s, input logic st);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i], (i == 0) ? st : 1'b0);
        end
    endtask

    task automatic drain();
        tx_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic end_phase();
        send_char(CH_NUL, 1'b1);
        drain();
    endtask

    task automatic write_ts(input logic v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        sb.ts_flag = v;
    endtask

    function automatic logic [7:0] pick_body();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return HOT_CHARS[$urandom_range(0, 15)];
        end else if (r < 95) begin
            return 8'($urandom_range(33, 126));
        end
        return 8'($urandom_range(1, 255));
    endfunction

    task automatic random_scan();
        bit lead;
        int r;
        int n;
        lead = 1'b1;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            repeat ($urandom_range(1, 6)) begin
                send_char(8'($urandom), $urandom_range(0, 3) == 0);
            end
            return;
        end
        repeat ($urandom_range(0, 2)) begin
            send_char(BLANKS[$urandom_range(0, 3)], lead);
            lead = 1'b0;
        end
        if (r < 17) begin
            send_char(REJECTS[$urandom_range(0, 3)], lead);
            return;
        end
        n = $urandom_range(1, 24);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                send_char(CH_DOLLAR, lead);
                send_char(CH_LBRACE, 1'b0);
            end else begin
                send_char(pick_body(), lead);
            end
            lead = 1'b0;
        end
        r = $urandom_range(0, 9);
        if (r < 6) begin
            send_char(CH_NUL, 1'b0);
        end else if (r < 8) begin
            send_char(CH_RBRACE, 1'b0);
        end
    endtask

    task automatic random_run(input int upto);
        while (sb.n_live < upto) begin
            if (!hold_done && sb.n_live >= 200) begin
                hold_req = 1'b1;
                hold_done = 1'b1;
            end
            quiet = (sb.n_live >= 500 && sb.n_live < 700);
            random_scan();
        end
        quiet = 1'b0;
    endtask

    initial begin
        #40_000_000;
        $display("tb_balanced_expression_scanner_core: done, errors");
        $finish;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;
        write_ts(1'b1);

        send_char(CH_SPACE, 1'b1);
        send_char(CH_TAB, 1'b0);
        send_char(CH_LF, 1'b0);
        send_char(CH_CR, 1'b0);
        send_str("a+b", 1'b0);
        send_char(CH_NUL, 1'b0);
        send_str("#x", 1'b1);
        send_char(CH_COLON, 1'b1);
        send_char(CH_AT, 1'b1);
        send_char(CH_SLASH, 1'b1);
        send_char(CH_RBRACE, 1'b1);
        send_char(CH_NUL, 1'b1);
        send_str("([{}])}", 1'b1);
        send_str("a)", 1'b1);
        send_str("'x\\'y'", 1'b1);
        send_char(CH_NUL, 1'b0);
        send_str("`a${b{c}d'e'}f`}", 1'b1);
        send_str("\"$(\"]", 1'b1);
        send_str("'\\", 1'b1);
        send_char(CH_NUL, 1'b0);
        send_str("`$", 1'b1);
        send_char(CH_NUL, 1'b0);
        send_str("abc", 1'b1);
        send_str("x", 1'b1);
        send_char(CH_NUL, 1'b0);
        for (int k = 0; k < 8; k++) begin
            send_str("`${", k == 0);
        end
        send_char(CH_BQUOTE, 1'b0);
        send_str("`${", 1'b1);
        repeat (511) send_char(CH_LBRACE, 1'b0);
        end_phase();

        write_ts(1'b0);
        random_run(FIRST_TARGET);
        end_phase();

        write_ts(1'b1);
        random_run(LIVE_TARGET);
        end_phase();

        send_str("(x)", 1'b1);
        send_char(CH_NUL, 1'b0);
        drain();
        repeat (8) @(posedge i_clk);

        if (sb.n_bad == 0 && sb.pending() == 0) begin
            $display("tb_balanced_expression_scanner_core: done, clean");
        end else begin
            $display("tb_balanced_expression_scanner_core: done, errors");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
hdl/bes_pkg.sv
hdl/bes_stack_cell.sv
hdl/bes_stack.sv
hdl/balanced_expression_scanner_core.sv
sim/tb_balanced_expression_scanner_core.sv
